// ===== design/slle_pkg.sv =====
// ----------------------------------------------------------------------------
// slle_pkg
// Shared types and codes for the static linked list engine: opcodes, status
// codes, controller states, datapath actions and the transaction structs.
// ----------------------------------------------------------------------------
package slle_pkg;

  typedef enum logic [2:0] {
    OP_ADD_HEAD  = 3'd0,
    OP_ADD_AFTER = 3'd1,
    OP_ADD_TAIL  = 3'd2,
    OP_DEL_HEAD  = 3'd3,
    OP_DEL_AFTER = 3'd4,
    OP_DEL_TAIL  = 3'd5,
    OP_CLEAR     = 3'd6,
    OP_WALK      = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_UNUSED = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_ADD_HEAD,
    S_ADD_LINK,
    S_ADD_FIX,
    S_TAIL_CHK,
    S_TAIL_ADV,
    S_DH_WAIT,
    S_DEL_HEAD,
    S_DA_WAIT,
    S_DA_ADV,
    S_DA_WAIT2,
    S_DEL_AFTER,
    S_LT_FIRST,
    S_LT_CHK,
    S_LT_ADV,
    S_WALK_RD,
    S_WALK_EMIT,
    S_RESP
  } state_t;

  typedef enum logic [3:0] {
    A_NONE,
    A_LATCH,
    A_CUR_HEAD,
    A_CUR_PIDX,
    A_CUR_NEXT,
    A_SCAN_STEP,
    A_ADD_HEAD,
    A_ADD_LINK,
    A_ADD_FIX,
    A_DEL_HEAD,
    A_DEL_AFTER,
    A_CLEAR
  } act_t;

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_CUR,
    RS_SCAN
  } slot_sel_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [3:0]  slot_index;
    logic [31:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  element_count;
    logic [3:0]  result_slot;
    logic [31:0] result_data;
    logic        last_result;
  } out_item_t;

  typedef struct packed {
    act_t      act;
    logic      emit;
    status_t   res_st;
    slot_sel_t res_slot;
    logic      res_walk;
  } dp_cmd_t;

  typedef struct packed {
    opcode_t op;
    logic    full;
    logic    empty;
    logic    pidx_ok;
    logic    pidx_tail;
    logic    cur_tail;
    logic    scan_hit;
  } dp_stat_t;

endpackage

// ===== design/slle_ctrl.sv =====
// ----------------------------------------------------------------------------
// slle_ctrl
// Command sequencer: decodes the latched opcode and steps the datapath through
// scans, link walks and table updates, one action per cycle.
// ----------------------------------------------------------------------------
module slle_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  slle_pkg::dp_stat_t stat,
  output slle_pkg::dp_cmd_t  cmd
);

  slle_pkg::state_t  state_r;
  slle_pkg::state_t  state_nxt;

  slle_pkg::act_t    dec_act;
  logic              dec_err;
  slle_pkg::status_t dec_code;
  slle_pkg::state_t  dec_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slle_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != slle_pkg::S_IDLE);

  // first look at a fresh command: error checks and the first action
  always_comb begin
    dec_act  = slle_pkg::A_NONE;
    dec_err  = 1'b0;
    dec_code = slle_pkg::ST_OK;
    dec_go   = slle_pkg::S_IDLE;
    unique case (stat.op)
      slle_pkg::OP_ADD_HEAD: begin
        if (stat.full) begin
          dec_err  = 1'b1;
          dec_code = slle_pkg::ST_FULL;
        end else begin
          dec_go = slle_pkg::S_SCAN;
        end
      end
      slle_pkg::OP_ADD_AFTER: begin
        priority if (stat.full) begin
          dec_err  = 1'b1;
          dec_code = slle_pkg::ST_FULL;
        end else if (!stat.pidx_ok) begin
          dec_err  = 1'b1;
          dec_code = slle_pkg::ST_UNUSED;
        end else begin
          dec_act = slle_pkg::A_CUR_PIDX;
          dec_go  = slle_pkg::S_SCAN;
        end
      end
      slle_pkg::OP_ADD_TAIL: begin
        priority if (stat.empty) begin
          dec_go = slle_pkg::S_SCAN;
        end else if (stat.full) begin
          dec_err  = 1'b1;
          dec_code = slle_pkg::ST_FULL;
        end else begin
          dec_act = slle_pkg::A_CUR_HEAD;
          dec_go  = slle_pkg::S_TAIL_CHK;
        end
      end
      slle_pkg::OP_DEL_HEAD: begin
        if (stat.empty) begin
          dec_err  = 1'b1;
          dec_code = slle_pkg::ST_EMPTY;
        end else begin
          dec_act = slle_pkg::A_CUR_HEAD;
          dec_go  = slle_pkg::S_DH_WAIT;
        end
      end
      slle_pkg::OP_DEL_AFTER: begin
        priority if (!stat.pidx_ok) begin
          dec_err  = 1'b1;
          dec_code = slle_pkg::ST_UNUSED;
        end else if (stat.pidx_tail) begin
          dec_err  = 1'b1;
          dec_code = slle_pkg::ST_EMPTY;
        end else begin
          dec_act = slle_pkg::A_CUR_PIDX;
          dec_go  = slle_pkg::S_DA_WAIT;
        end
      end
      slle_pkg::OP_DEL_TAIL: begin
        if (stat.empty) begin
          dec_err  = 1'b1;
          dec_code = slle_pkg::ST_EMPTY;
        end else begin
          dec_act = slle_pkg::A_CUR_HEAD;
          dec_go  = slle_pkg::S_LT_FIRST;
        end
      end
      slle_pkg::OP_CLEAR: begin
        dec_act = slle_pkg::A_CLEAR;
        dec_go  = slle_pkg::S_RESP;
      end
      slle_pkg::OP_WALK: begin
        if (stat.empty) begin
          dec_err  = 1'b1;
          dec_code = slle_pkg::ST_EMPTY;
        end else begin
          dec_act = slle_pkg::A_CUR_HEAD;
          dec_go  = slle_pkg::S_WALK_RD;
        end
      end
      default: begin
        dec_act = slle_pkg::A_NONE;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      slle_pkg::S_IDLE: begin
        if (start) state_nxt = slle_pkg::S_DECODE;
      end
      slle_pkg::S_DECODE:   state_nxt = dec_go;
      slle_pkg::S_SCAN: begin
        if (stat.scan_hit) begin
          if (stat.op == slle_pkg::OP_ADD_HEAD ||
              (stat.op == slle_pkg::OP_ADD_TAIL && stat.empty)) begin
            state_nxt = slle_pkg::S_ADD_HEAD;
          end else begin
            state_nxt = slle_pkg::S_ADD_LINK;
          end
        end
      end
      slle_pkg::S_ADD_HEAD: state_nxt = slle_pkg::S_RESP;
      slle_pkg::S_ADD_LINK: state_nxt = slle_pkg::S_ADD_FIX;
      slle_pkg::S_ADD_FIX:  state_nxt = slle_pkg::S_RESP;
      slle_pkg::S_TAIL_CHK: begin
        state_nxt = stat.cur_tail ? slle_pkg::S_SCAN : slle_pkg::S_TAIL_ADV;
      end
      slle_pkg::S_TAIL_ADV:  state_nxt = slle_pkg::S_TAIL_CHK;
      slle_pkg::S_DH_WAIT:   state_nxt = slle_pkg::S_DEL_HEAD;
      slle_pkg::S_DEL_HEAD:  state_nxt = slle_pkg::S_RESP;
      slle_pkg::S_DA_WAIT:   state_nxt = slle_pkg::S_DA_ADV;
      slle_pkg::S_DA_ADV:    state_nxt = slle_pkg::S_DA_WAIT2;
      slle_pkg::S_DA_WAIT2:  state_nxt = slle_pkg::S_DEL_AFTER;
      slle_pkg::S_DEL_AFTER: state_nxt = slle_pkg::S_RESP;
      slle_pkg::S_LT_FIRST: begin
        state_nxt = stat.cur_tail ? slle_pkg::S_DEL_HEAD : slle_pkg::S_LT_ADV;
      end
      slle_pkg::S_LT_ADV:    state_nxt = slle_pkg::S_LT_CHK;
      slle_pkg::S_LT_CHK: begin
        state_nxt = stat.cur_tail ? slle_pkg::S_DEL_AFTER : slle_pkg::S_LT_ADV;
      end
      slle_pkg::S_WALK_RD:   state_nxt = slle_pkg::S_WALK_EMIT;
      slle_pkg::S_WALK_EMIT: begin
        state_nxt = stat.cur_tail ? slle_pkg::S_IDLE : slle_pkg::S_WALK_RD;
      end
      slle_pkg::S_RESP:      state_nxt = slle_pkg::S_IDLE;
      default:               state_nxt = slle_pkg::S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    unique case (state_r)
      slle_pkg::S_IDLE: begin
        if (start) cmd.act = slle_pkg::A_LATCH;
      end
      slle_pkg::S_DECODE: begin
        cmd.act    = dec_act;
        cmd.emit   = dec_err;
        cmd.res_st = dec_code;
      end
      slle_pkg::S_SCAN:      cmd.act = slle_pkg::A_SCAN_STEP;
      slle_pkg::S_ADD_HEAD:  cmd.act = slle_pkg::A_ADD_HEAD;
      slle_pkg::S_ADD_LINK:  cmd.act = slle_pkg::A_ADD_LINK;
      slle_pkg::S_ADD_FIX:   cmd.act = slle_pkg::A_ADD_FIX;
      slle_pkg::S_TAIL_ADV,
      slle_pkg::S_DA_ADV,
      slle_pkg::S_LT_ADV:    cmd.act = slle_pkg::A_CUR_NEXT;
      slle_pkg::S_DEL_HEAD:  cmd.act = slle_pkg::A_DEL_HEAD;
      slle_pkg::S_DEL_AFTER: cmd.act = slle_pkg::A_DEL_AFTER;
      slle_pkg::S_WALK_EMIT: begin
        cmd.emit     = 1'b1;
        cmd.res_slot = slle_pkg::RS_CUR;
        cmd.res_walk = 1'b1;
        cmd.act      = stat.cur_tail ? slle_pkg::A_NONE : slle_pkg::A_CUR_NEXT;
      end
      slle_pkg::S_RESP: begin
        cmd.emit = 1'b1;
        if (stat.op == slle_pkg::OP_ADD_HEAD || stat.op == slle_pkg::OP_ADD_AFTER ||
            stat.op == slle_pkg::OP_ADD_TAIL) begin
          cmd.res_slot = slle_pkg::RS_SCAN;
        end else if (stat.op == slle_pkg::OP_CLEAR) begin
          cmd.res_slot = slle_pkg::RS_ZERO;
        end else begin
          cmd.res_slot = slle_pkg::RS_CUR;
        end
      end
      default: cmd.act = slle_pkg::A_NONE;
    endcase
  end

endmodule

// ===== design/slle_datapath.sv =====
// ----------------------------------------------------------------------------
// slle_datapath
// Slot table (used and tail marks in flops, next links and data words in
// memories with registered reads), list head and count, walk pointers and the
// result register.
// ----------------------------------------------------------------------------
module slle_datapath #(
  parameter int SLOTS      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  slle_pkg::in_item_t  in_item,
  input  slle_pkg::dp_cmd_t   cmd,
  output slle_pkg::dp_stat_t  stat,
  output logic                out_valid,
  output slle_pkg::out_item_t out_item
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  slle_pkg::opcode_t     op_r;
  logic [3:0]            pidx_r;
  logic [DATA_WIDTH-1:0] din_r;
  logic [SW-1:0]         cur_r;
  logic [SW-1:0]         prev_r;
  logic [SW-1:0]         scan_r;
  logic [SW-1:0]         head_r;
  logic                  empty_r;
  logic [CW-1:0]         total_r;
  logic [SLOTS-1:0]      used_r;
  logic [SLOTS-1:0]      tail_r;

  logic [SW-1:0]         next_mem [SLOTS];
  logic [DATA_WIDTH-1:0] data_mem [SLOTS];
  logic [SW-1:0]         nrd_r;
  logic [DATA_WIDTH-1:0] drd_r;

  logic                  out_valid_r;
  slle_pkg::out_item_t   out_r;

  logic [DATA_WIDTH+31:0] din_ext;
  logic [DATA_WIDTH+31:0] dout_ext;
  logic [SW+3:0]          pidx_ext;
  logic [SW-1:0]          pslot;
  logic [CW+4:0]          total_ext;
  logic [SW+3:0]          slot_ext;
  logic [SW-1:0]          res_slot;

  logic                  nw_en;
  logic [SW-1:0]         nw_addr;
  logic [SW-1:0]         nw_data;
  logic                  dw_en;

  assign din_ext   = {{DATA_WIDTH{1'b0}}, in_item.entry_data};
  assign dout_ext  = {32'd0, drd_r};
  assign pidx_ext  = {{SW{1'b0}}, pidx_r};
  assign pslot     = pidx_ext[SW-1:0];
  assign total_ext = {5'd0, total_r};

  always_comb begin
    stat.op        = op_r;
    stat.full      = (total_r == CW'(SLOTS));
    stat.empty     = empty_r;
    // an index beyond the table is reported the same as an unused slot
    stat.pidx_ok   = ({28'd0, pidx_r} < 32'(SLOTS)) && used_r[pslot];
    stat.pidx_tail = tail_r[pslot];
    stat.cur_tail  = tail_r[cur_r];
    stat.scan_hit  = !used_r[scan_r];
  end

  // link memory write port
  always_comb begin
    nw_en   = 1'b0;
    nw_addr = scan_r;
    nw_data = nrd_r;
    unique case (cmd.act)
      slle_pkg::A_ADD_HEAD: begin
        nw_en   = !empty_r;
        nw_addr = scan_r;
        nw_data = head_r;
      end
      slle_pkg::A_ADD_LINK: begin
        nw_en   = 1'b1;
        nw_addr = scan_r;
        nw_data = nrd_r;
      end
      slle_pkg::A_ADD_FIX: begin
        nw_en   = 1'b1;
        nw_addr = cur_r;
        nw_data = scan_r;
      end
      slle_pkg::A_DEL_AFTER: begin
        nw_en   = 1'b1;
        nw_addr = prev_r;
        nw_data = nrd_r;
      end
      default: nw_en = 1'b0;
    endcase
  end

  assign dw_en = (cmd.act == slle_pkg::A_ADD_HEAD) || (cmd.act == slle_pkg::A_ADD_LINK);

  always_ff @(posedge clk) begin
    if (nw_en) next_mem[nw_addr] <= nw_data;
    if (dw_en) data_mem[scan_r] <= din_r;
    nrd_r <= next_mem[cur_r];
    drd_r <= data_mem[cur_r];
  end

  // command registers and walk pointers
  always_ff @(posedge clk) begin
    unique case (cmd.act)
      slle_pkg::A_LATCH: begin
        op_r   <= slle_pkg::opcode_t'(in_item.opcode);
        pidx_r <= in_item.slot_index;
        din_r  <= din_ext[DATA_WIDTH-1:0];
        scan_r <= '0;
      end
      slle_pkg::A_CUR_HEAD: cur_r <= head_r;
      slle_pkg::A_CUR_PIDX: cur_r <= pslot;
      slle_pkg::A_CUR_NEXT: begin
        prev_r <= cur_r;
        cur_r  <= nrd_r;
      end
      slle_pkg::A_SCAN_STEP: begin
        if (used_r[scan_r]) scan_r <= scan_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // list state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      empty_r <= 1'b1;
      total_r <= '0;
      used_r  <= '0;
      tail_r  <= '0;
    end else begin
      unique case (cmd.act)
        slle_pkg::A_ADD_HEAD: begin
          used_r[scan_r] <= 1'b1;
          tail_r[scan_r] <= empty_r;
          total_r        <= total_r + 1'b1;
          head_r         <= scan_r;
          empty_r        <= 1'b0;
        end
        slle_pkg::A_ADD_LINK: begin
          used_r[scan_r] <= 1'b1;
          tail_r[scan_r] <= tail_r[cur_r];
          tail_r[cur_r]  <= 1'b0;
          total_r        <= total_r + 1'b1;
        end
        slle_pkg::A_DEL_HEAD: begin
          if (tail_r[cur_r]) begin
            empty_r <= 1'b1;
            head_r  <= '0;
          end else begin
            head_r <= nrd_r;
          end
          used_r[cur_r] <= 1'b0;
          tail_r[cur_r] <= 1'b0;
          total_r       <= total_r - 1'b1;
        end
        slle_pkg::A_DEL_AFTER: begin
          tail_r[prev_r] <= tail_r[cur_r];
          used_r[cur_r]  <= 1'b0;
          tail_r[cur_r]  <= 1'b0;
          total_r        <= total_r - 1'b1;
        end
        slle_pkg::A_CLEAR: begin
          head_r  <= '0;
          empty_r <= 1'b1;
          total_r <= '0;
          used_r  <= '0;
          tail_r  <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_comb begin
    unique case (cmd.res_slot)
      slle_pkg::RS_CUR:  res_slot = cur_r;
      slle_pkg::RS_SCAN: res_slot = scan_r;
      default:           res_slot = '0;
    endcase
  end

  assign slot_ext = {4'd0, res_slot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status        <= cmd.res_st;
      out_r.element_count <= total_ext[4:0];
      out_r.result_slot   <= slot_ext[3:0];
      out_r.result_data   <= cmd.res_walk ? dout_ext[31:0] : 32'd0;
      out_r.last_result   <= cmd.res_walk ? tail_r[cur_r] : 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ===== design/static_linked_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// static_linked_list_engine_top
// Singly linked list kept in a fixed slot table; add, delete, clear and walk.
// ----------------------------------------------------------------------------
// latency from accept to out_valid depends on the command: errors report straight from decode;
// clear resets the table, then responds; add head and add after scan for a free slot; add tail
// first follows the links to the tail, then runs the one-slot-a-cycle free scan; deletes
// read the links they need; walk gives one result per element in list order, last_result on the tail
// throughput: one command at a time; busy falls as the last result is registered
// reset: synchronous, clears to an empty list; out_valid strobes, receiver cannot stall
module static_linked_list_engine_top #(
  parameter int SLOTS      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  slle_pkg::in_item_t  in_item,
  output logic                out_valid,
  output slle_pkg::out_item_t out_item
);

  slle_pkg::dp_cmd_t  cmd;
  slle_pkg::dp_stat_t stat;

  slle_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  slle_datapath #(
    .SLOTS      (SLOTS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // an accepted transaction keeps the engine busy on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("engine not busy after accepting a transaction");

  // failed commands end at once and report no slot
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.status != slle_pkg::ST_OK |->
      out_item.last_result && out_item.result_slot == 4'd0 &&
      out_item.result_data == 32'd0)
    else $error("error result is not a final, empty result");

  // a walk in progress still holds the engine
  a_walk_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item.last_result |-> busy)
    else $error("non-final result while engine is idle");

endmodule
